// ===== hw/rtl/fpte_pkg.sv =====
// ----------------------------------------------------------------------------
// fpte_pkg
// Shared types, codes and helpers for the four-level page table engine.
// ----------------------------------------------------------------------------
package fpte_pkg;

  // store geometry
  localparam int unsigned TABLE_FRAMES_DEF  = 16;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned QUEUE_DEPTH       = 2;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VA_W    = 64;
  localparam int unsigned PA_W    = 52;
  localparam int unsigned FLAGS_W = 64;
  localparam int unsigned FRAME_W = 40;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned FIRST_FREE_W = 4;

  // entry flag bits
  localparam int unsigned F_PRESENT_BIT  = 0;
  localparam int unsigned F_WRITABLE_BIT = 1;
  localparam int unsigned F_USER_BIT     = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNMAP = 2'd1;

  // request kind after classification
  typedef enum logic [1:0] {
    KIND_MAP,
    KIND_UNMAP,
    KIND_XLATE
  } kind_t;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_ABSENT   = 3'd1;
  localparam logic [ST_W-1:0] ST_ALIGN    = 3'd2;
  localparam logic [ST_W-1:0] ST_NOFRAME  = 3'd3;
  localparam logic [ST_W-1:0] ST_OUTSIDE  = 3'd4;
  localparam logic [ST_W-1:0] ST_ZEROROOT = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROOT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE  = 2'd2;

  // classified request travelling from front to back
  typedef struct packed {
    kind_t                kind;
    logic [ST_W-1:0]      pre_status;
    logic [VA_W-1:0]      va;
    logic [PA_W-1:0]      pa;
    logic [FLAGS_W-1:0]   flags;
    logic [FRAME_W-1:0]   root;
  } req_t;

  // queue fill state
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // back-end status seen by the front
  typedef struct packed {
    logic clearing;
  } back_status_t;

  // table index of a virtual address at a walk level (0 is the top)
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] level);
    logic [IDX_W-1:0] idx;
    begin
      case (level)
        2'd0:    idx = va[47:39];
        2'd1:    idx = va[38:30];
        2'd2:    idx = va[29:21];
        default: idx = va[20:12];
      endcase
      return idx;
    end
  endfunction

endpackage

// ===== hw/rtl/fpte_front.sv =====
// ----------------------------------------------------------------------------
// fpte_front
// Takes requests, sorts them by kind, flags early failures and picks the root.
// ----------------------------------------------------------------------------
module fpte_front import fpte_pkg::*; (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [VA_W-1:0]    vaddr,
  input  logic [PA_W-1:0]    paddr,
  input  logic [FLAGS_W-1:0] page_flags,
  input  logic [FRAME_W-1:0] root_frame,
  input  logic [FRAME_W-1:0] kernel_root_frame,
  input  back_status_t       back_st,
  input  q_status_t          q_st,
  output logic               push,
  output req_t               push_req
);

  logic va_mis;
  logic pa_mis;

  // transfer when the queue has room and the store is not being cleared
  assign in_ready = !back_st.clearing && !q_st.full;
  assign push     = in_valid && in_ready;

  assign va_mis = (vaddr[11:0] != 12'h000);
  assign pa_mis = (paddr[11:0] != 12'h000);

  // classify and check
  always_comb begin
    push_req.va         = vaddr;
    push_req.pa         = paddr;
    push_req.flags      = '0;
    push_req.root       = kernel_root_frame;
    push_req.pre_status = ST_OK;
    unique case (operation)
      OP_MAP: begin
        push_req.kind  = KIND_MAP;
        push_req.flags = page_flags;
        push_req.root  = root_frame;
        if (root_frame == '0) begin
          push_req.pre_status = ST_ZEROROOT;
        end else if (va_mis || pa_mis) begin
          push_req.pre_status = ST_ALIGN;
        end
      end
      OP_UNMAP: begin
        push_req.kind = KIND_UNMAP;
        if (va_mis) begin
          push_req.pre_status = ST_ALIGN;
        end
      end
      default: begin
        push_req.kind = KIND_XLATE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fpte_queue.sv =====
// ----------------------------------------------------------------------------
// fpte_queue
// Short request queue between the front and the walker.
// ----------------------------------------------------------------------------
module fpte_queue import fpte_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  req_t      push_req,
  input  logic      pop,
  output req_t      head,
  output q_status_t q_st
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  req_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = slots[rd_ptr];
  assign q_st.full  = (count == CW'(QUEUE_DEPTH));
  assign q_st.empty = (count == '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

// ===== hw/rtl/fpte_back.sv =====
// ----------------------------------------------------------------------------
// fpte_back
// Table walker: owns the table store, the frame allocator and the result register.
// ----------------------------------------------------------------------------
module fpte_back import fpte_pkg::*; #(
  parameter int unsigned TABLE_FRAMES = TABLE_FRAMES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  q_status_t               q_st,
  input  req_t                    head,
  output logic                    pop,
  input  logic [FRAME_W-1:0]      store_base_frame,
  input  logic [FIRST_FREE_W-1:0] first_free_frame,
  output back_status_t            back_st,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    success,
  output logic [PA_W-1:0]         translated_address,
  output logic [ST_W-1:0]         status
);

  localparam int unsigned FW    = $clog2(TABLE_FRAMES);
  localparam int unsigned MW    = FW + IDX_W;
  localparam int unsigned DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam int unsigned NW    = $clog2(TABLE_FRAMES + 16) + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_READ,
    S_EVAL,
    S_ZERO,
    S_LINK
  } state_t;

  state_t             state;
  logic [1:0]         level;
  kind_t              kind;
  logic [VA_W-1:0]    va;
  logic [PA_W-1:0]    pa;
  logic [FLAGS_W-1:0] flags;
  logic [FRAME_W-1:0] cur_frame;
  logic [FW-1:0]      slot;
  logic [NW-1:0]      alloc;
  logic [FW-1:0]      zframe;
  logic [IDX_W-1:0]   zidx;
  logic [63:0]        ent;
  logic [MW-1:0]      clr_addr;

  // table store
  logic [63:0]        mem [DEPTH];
  logic [63:0]        rdata;
  logic               we;
  logic [MW-1:0]      waddr;
  logic [63:0]        wdata;
  logic               re;

  // walk helpers
  logic [MW-1:0]      cur_addr;
  logic [FRAME_W:0]   frame_off;
  logic               outside;
  logic [NW-1:0]      next_frame;
  logic               no_frame;
  logic [FRAME_W-1:0] new_pframe;
  logic [63:0]        new_entry;
  logic               present;
  logic               user_req;
  logic [63:0]        leaf_map;

  // a frame below the store base borrows and lies outside the store
  assign cur_addr   = {slot, level_index(va, level)};
  assign frame_off  = {1'b0, cur_frame} - {1'b0, store_base_frame};
  assign outside    = frame_off[FRAME_W] ||
                      (frame_off[FRAME_W-1:0] >= FRAME_W'(TABLE_FRAMES));
  assign next_frame = NW'(first_free_frame) + alloc;
  assign no_frame   = (next_frame >= NW'(TABLE_FRAMES));
  assign new_pframe = store_base_frame + FRAME_W'(next_frame);
  assign user_req   = flags[F_USER_BIT];
  assign present    = rdata[F_PRESENT_BIT];
  assign new_entry  = {12'h000, new_pframe, 9'h000, user_req, 2'b11};
  assign leaf_map   = {12'h000, pa[PA_W-1:12], 12'h000} | flags | 64'h1;

  assign back_st.clearing = (state == S_CLEAR);
  assign pop = (state == S_IDLE) && !q_st.empty && !out_valid;
  assign re  = (state == S_READ);

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = '0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      S_ZERO: begin
        we    = 1'b1;
        waddr = {zframe, zidx};
      end
      S_LINK: begin
        we    = 1'b1;
        wdata = ent;
      end
      S_EVAL: begin
        if (level != 2'd3) begin
          if (present && user_req) begin
            we    = 1'b1;
            wdata = rdata | 64'h4;
          end
        end else if (kind == KIND_MAP) begin
          we    = !present;
          wdata = leaf_map;
        end else if (kind == KIND_UNMAP) begin
          we    = present;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // store array with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[cur_addr];
    end
  end

  // walk sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      alloc     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == MW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            kind      <= head.kind;
            va        <= head.va;
            pa        <= head.pa;
            flags     <= head.flags;
            cur_frame <= head.root;
            level     <= 2'd0;
            if (head.pre_status != ST_OK) begin
              out_valid          <= 1'b1;
              success            <= 1'b0;
              translated_address <= '0;
              status             <= head.pre_status;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (outside) begin
            out_valid          <= 1'b1;
            success            <= 1'b0;
            translated_address <= '0;
            status             <= ST_OUTSIDE;
            state              <= S_IDLE;
          end else begin
            slot  <= frame_off[FW-1:0];
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (level != 2'd3) begin
            if (present) begin
              cur_frame <= rdata[51:12];
              level     <= level + 1'b1;
              state     <= S_WALK;
            end else if (kind != KIND_MAP) begin
              out_valid          <= 1'b1;
              success            <= 1'b0;
              translated_address <= '0;
              status             <= ST_ABSENT;
              state              <= S_IDLE;
            end else if (no_frame) begin
              out_valid          <= 1'b1;
              success            <= 1'b0;
              translated_address <= '0;
              status             <= ST_NOFRAME;
              state              <= S_IDLE;
            end else begin
              alloc  <= alloc + 1'b1;
              zframe <= next_frame[FW-1:0];
              zidx   <= '0;
              ent    <= new_entry;
              state  <= S_ZERO;
            end
          end else begin
            out_valid          <= 1'b1;
            translated_address <= '0;
            state              <= S_IDLE;
            if (present == (kind == KIND_MAP)) begin
              success <= 1'b0;
              status  <= ST_ABSENT;
            end else begin
              success <= 1'b1;
              status  <= ST_OK;
              if (kind == KIND_XLATE) begin
                translated_address <= {rdata[51:12], va[11:0]};
              end
            end
          end
        end
        S_ZERO: begin
          zidx <= zidx + 1'b1;
          if (zidx == IDX_W'(ENTRIES_PER_TABLE - 1)) begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          cur_frame <= ent[51:12];
          level     <= level + 1'b1;
          state     <= S_WALK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/four_level_page_table_engine.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_engine
// Four-level page table store with map, unmap and translate requests.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  request  | in_valid / in_ready  | operation, vaddr, paddr,
//           |                      | page_flags, root_frame
//  result   | out_valid / out_ready| success, translated_address, status
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a request rejected up front gets its result from the idle state without a walk;
// a walk goes through frame check, store read and evaluate at each level.
// each table created on a map is zeroed entry by entry and then linked in.
// after reset a pass clears all TABLE_FRAMES*512 store words; requests wait meanwhile.
// a two-entry queue lets requests be taken while a result waits for out_ready.
module four_level_page_table_engine import fpte_pkg::*; #(
  parameter int unsigned TABLE_FRAMES = TABLE_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       operation,
  input  logic [VA_W-1:0]       vaddr,
  input  logic [PA_W-1:0]       paddr,
  input  logic [FLAGS_W-1:0]    page_flags,
  input  logic [FRAME_W-1:0]    root_frame,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  success,
  output logic [PA_W-1:0]       translated_address,
  output logic [ST_W-1:0]       status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FRAME_W-1:0]      kernel_root_frame;
  logic [FRAME_W-1:0]      store_base_frame;
  logic [FIRST_FREE_W-1:0] first_free_frame;

  logic         push;
  req_t         push_req;
  logic         pop;
  req_t         head;
  q_status_t    q_st;
  back_status_t back_st;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_root_frame <= '0;
      store_base_frame  <= '0;
      first_free_frame  <= FIRST_FREE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KERNEL_ROOT: kernel_root_frame <= cfg_data;
        CFG_STORE_BASE:  store_base_frame  <= cfg_data;
        CFG_FIRST_FREE:  first_free_frame  <= cfg_data[FIRST_FREE_W-1:0];
        default: begin
          kernel_root_frame <= kernel_root_frame;
        end
      endcase
    end
  end

  fpte_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation         (operation),
    .vaddr             (vaddr),
    .paddr             (paddr),
    .page_flags        (page_flags),
    .root_frame        (root_frame),
    .kernel_root_frame (kernel_root_frame),
    .back_st           (back_st),
    .q_st              (q_st),
    .push              (push),
    .push_req          (push_req)
  );

  fpte_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .q_st     (q_st)
  );

  fpte_back #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_st               (q_st),
    .head               (head),
    .pop                (pop),
    .store_base_frame   (store_base_frame),
    .first_free_frame   (first_free_frame),
    .back_st            (back_st),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .success            (success),
    .translated_address (translated_address),
    .status             (status)
  );

endmodule

// ===== verif/four_level_page_table_engine_test.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_engine_test
// Drives map, unmap and translate requests into the page table engine and
// compares every result against a walk predictor that keeps its own copy of
// the table store, allocator and registers. Idling on both channels is changed
// for the last two phases, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module four_level_page_table_engine_test;
  import fpte_pkg::*;

  localparam logic [OP_W-1:0] OP_XLATE = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [63:0] ADDR_MASK = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] MASK40    = 64'h0000_00ff_ffff_ffff;
  localparam logic [39:0] FRAME_MAX = 40'hff_ffff_ffff;
  localparam int unsigned STORE_WORDS = TABLE_FRAMES_DEF * ENTRIES_PER_TABLE;

  typedef struct packed {
    logic            ok;
    logic [PA_W-1:0] xlat;
    logic [ST_W-1:0] st;
  } walk_result_t;

  // predictor of the walk engine plus the queue of results still owed
  class page_walk_scoreboard;
    logic [63:0]       tables [STORE_WORDS];
    logic [4:0]        allocated;
    logic [39:0]       kernel_root;
    logic [39:0]       base_frame;
    logic [3:0]        first_free;
    walk_result_t      owed [$];
    int                mismatches;

    function new();
      foreach (tables[i]) tables[i] = '0;
      allocated   = '0;
      kernel_root = '0;
      base_frame  = '0;
      first_free  = 4'd1;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_KERNEL_ROOT: kernel_root = data;
        CFG_STORE_BASE:  base_frame  = data;
        CFG_FIRST_FREE:  first_free  = data[FIRST_FREE_W-1:0];
        default: ;
      endcase
    endfunction

    // store frame of a physical frame, or -1 when it lies outside the store
    function int slot_of(logic [63:0] pframe);
      logic [63:0] d;
      d = (pframe & MASK40) - {24'b0, base_frame};
      if (d >= TABLE_FRAMES_DEF) return -1;
      return int'(d);
    endfunction

    // upper three levels; creates missing tables when asked
    function logic [ST_W-1:0] walk_upper(logic [39:0] root, logic [63:0] va, bit create,
                                         logic [63:0] flags, output int leaf_slot);
      int          slot;
      int          sh;
      int          addr;
      logic [63:0] nxt;
      logic [63:0] nf;
      leaf_slot = 0;
      slot = slot_of({24'b0, root});
      if (slot < 0) return ST_OUTSIDE;
      for (int lvl = 0; lvl < 3; lvl++) begin
        sh = 39 - 9 * lvl;
        addr = slot * ENTRIES_PER_TABLE + int'(va[sh +: 9]);
        if (!tables[addr][F_PRESENT_BIT]) begin
          if (!create) return ST_ABSENT;
          nxt = {60'b0, first_free} + {59'b0, allocated};
          if (nxt >= TABLE_FRAMES_DEF) return ST_NOFRAME;
          allocated++;
          for (int i = 0; i < ENTRIES_PER_TABLE; i++)
            tables[int'(nxt) * ENTRIES_PER_TABLE + i] = '0;
          nf = ({24'b0, base_frame} + nxt) & MASK40;
          tables[addr] = ((nf << 12) & ADDR_MASK) | 64'h3 | (flags & 64'h4);
        end else if (flags[F_USER_BIT]) begin
          tables[addr][F_USER_BIT] = 1'b1;
        end
        slot = slot_of((tables[addr] & ADDR_MASK) >> 12);
        if (slot < 0) return ST_OUTSIDE;
      end
      leaf_slot = slot;
      return ST_OK;
    endfunction

    // work out the result of one accepted request and queue it
    function void note_request(logic [OP_W-1:0] op, logic [63:0] va, logic [PA_W-1:0] pa,
                               logic [63:0] flags, logic [39:0] root);
      walk_result_t r;
      int           slot;
      int           addr;
      r = '0;
      if (op == OP_MAP) begin
        if (root == '0) r.st = ST_ZEROROOT;
        else if (va[11:0] != '0 || pa[11:0] != '0) r.st = ST_ALIGN;
        else begin
          r.st = walk_upper(root, va, 1'b1, flags, slot);
          if (r.st == ST_OK) begin
            addr = slot * ENTRIES_PER_TABLE + int'(va[20:12]);
            if (tables[addr][F_PRESENT_BIT]) r.st = ST_ABSENT;
            else tables[addr] = (({12'b0, pa}) & ADDR_MASK) | flags | 64'h1;
          end
        end
      end else if (op == OP_UNMAP) begin
        if (va[11:0] != '0) r.st = ST_ALIGN;
        else begin
          r.st = walk_upper(kernel_root, va, 1'b0, '0, slot);
          if (r.st == ST_OK) begin
            addr = slot * ENTRIES_PER_TABLE + int'(va[20:12]);
            if (!tables[addr][F_PRESENT_BIT]) r.st = ST_ABSENT;
            else tables[addr] = '0;
          end
        end
      end else begin
        r.st = walk_upper(kernel_root, va, 1'b0, '0, slot);
        if (r.st == ST_OK) begin
          addr = slot * ENTRIES_PER_TABLE + int'(va[20:12]);
          if (!tables[addr][F_PRESENT_BIT]) r.st = ST_ABSENT;
          else r.xlat = tables[addr][51:12] << 12 | {40'b0, va[11:0]};
        end
      end
      r.ok = (r.st == ST_OK);
      owed.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(logic ok, logic [PA_W-1:0] xlat, logic [ST_W-1:0] st);
      walk_result_t w;
      if (owed.size() == 0) begin
        report_mismatch("result with nothing outstanding");
        return;
      end
      w = owed.pop_front();
      if (ok !== w.ok) report_mismatch($sformatf("success %0b, want %0b", ok, w.ok));
      if (xlat !== w.xlat)
        report_mismatch($sformatf("translated_address %h, want %h", xlat, w.xlat));
      if (st !== w.st) report_mismatch($sformatf("status %0d, want %0d", st, w.st));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       operation = '0;
  logic [VA_W-1:0]       vaddr = '0;
  logic [PA_W-1:0]       paddr = '0;
  logic [FLAGS_W-1:0]    page_flags = '0;
  logic [FRAME_W-1:0]    root_frame = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  success;
  logic [PA_W-1:0]       translated_address;
  logic [ST_W-1:0]       status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  page_walk_scoreboard sb = new();

  four_level_page_table_engine u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // result transfers go to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(success, translated_address, status);
  end

  task send_request(logic [OP_W-1:0] op, logic [63:0] va, logic [PA_W-1:0] pa,
                    logic [63:0] flags, logic [39:0] root);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    vaddr      <= va;
    paddr      <= pa;
    page_flags <= flags;
    root_frame <= root;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, va, pa, flags, root);
  endtask

  task write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task drain_results();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // index into a small virtual region so that walks keep meeting existing tables
  function logic [8:0] pick_index(int unsigned spread);
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return 9'h1ff;
    if (r == 1) return 9'($urandom_range(511));
    return 9'($urandom_range(spread));
  endfunction

  task random_request();
    logic [OP_W-1:0] op;
    logic [63:0]     va;
    logic [PA_W-1:0] pa;
    logic [63:0]     flags;
    logic [39:0]     root;
    int unsigned     r;
    r = $urandom_range(19);
    op = (r < 8) ? OP_MAP : (r < 12) ? OP_UNMAP : (r < 19) ? OP_XLATE : OP_SPARE;
    va = {16'h0000, pick_index(0), pick_index(1), pick_index(1),
          pick_index(7), 12'h000};
    va[63:48] = 16'($urandom);
    if (op >= OP_XLATE || $urandom_range(9) == 0) va[11:0] = 12'($urandom);
    pa = {$urandom, 8'h0, 12'h000};
    pa[51:20] = $urandom;
    if ($urandom_range(19) == 0) pa[11:0] = 12'($urandom);
    flags = {$urandom, $urandom};
    r = $urandom_range(19);
    if (r < 16) root = sb.kernel_root;
    else if (r == 16) root = '0;
    else if (r == 17) root = {$urandom, 8'h0} | 40'($urandom);
    else root = sb.base_frame + 40'($urandom_range(15));
    send_request(op, va, pa, flags, root);
  endtask

  initial begin
    sender_idle_pct   = 14;
    receiver_idle_pct = 49;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset register values: rejects and empty walks
    write_register(CFG_KERNEL_ROOT, '0);
    send_request(OP_XLATE, 64'h0, '0, '0, '0);
    send_request(OP_MAP, 64'h0, '0, '0, '0);
    send_request(OP_MAP, 64'h1001, '0, '0, 40'd1);
    send_request(OP_MAP, 64'h1001, 52'h1, '0, '0);
    send_request(OP_MAP, 64'h1000, 52'h10, 64'h4, 40'd1);
    send_request(OP_UNMAP, 64'h2fff, '0, '0, '0);
    send_request(OP_UNMAP, 64'h0, '0, '0, '0);
    send_request(OP_SPARE, '1, '1, '1, FRAME_MAX);
    send_request(OP_MAP, 64'h0, '0, '0, FRAME_MAX);
    drain_results();

    // base at the top of the frame range, allocation from frame zero
    write_register(CFG_STORE_BASE, FRAME_MAX);
    write_register(CFG_KERNEL_ROOT, FRAME_MAX);
    write_register(CFG_FIRST_FREE, 4'd0);
    send_request(OP_MAP, '1 << 12, '1 << 12, '1, FRAME_MAX);
    send_request(OP_XLATE, 64'h0, '0, '0, '0);
    drain_results();

    // ordinary layout: kernel root in frame one, allocation from frame two
    write_register(CFG_STORE_BASE, '0);
    write_register(CFG_KERNEL_ROOT, 40'd1);
    write_register(CFG_FIRST_FREE, 4'd2);
    send_request(OP_MAP, 64'h1000, 52'hf_ffff_ffff_f000, 64'h6, 40'd1);
    send_request(OP_XLATE, 64'h1abc, '0, '0, '0);
    send_request(OP_MAP, 64'h1000, 52'h5000, 64'h0, 40'd1);
    send_request(OP_UNMAP, 64'h1000, '0, '0, '0);
    send_request(OP_XLATE, 64'h1abc, '0, '0, '0);
    send_request(OP_MAP, 64'hffff_ff80_0000_0000, 52'h7000, 64'h2, 40'd1);
    for (int i = 0; i < 900; i++) begin
      random_request();
      if (i == 450) drain_results();
    end
    drain_results();

    // highest first free frame, idling swapped
    write_register(CFG_FIRST_FREE, 4'd15);
    sender_idle_pct   = 49;
    receiver_idle_pct = 14;
    for (int i = 0; i < 450; i++) random_request();
    drain_results();

    // no idling on either side
    write_register(CFG_FIRST_FREE, 4'd3);
    write_register(CFG_KERNEL_ROOT, 40'd2);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    for (int i = 0; i < 400; i++) random_request();
    drain_results();

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(64'd2_000_000 * 20);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fpte_pkg.sv
hw/rtl/fpte_front.sv
hw/rtl/fpte_queue.sv
hw/rtl/fpte_back.sv
hw/rtl/four_level_page_table_engine.sv
verif/four_level_page_table_engine_test.sv
